### hdl/min_cost_covering_subset_search_unit_assert.svh
// Assertion macros for the min-cost covering subset search unit.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef MIN_COST_COVERING_SUBSET_SEARCH_UNIT_ASSERT_SVH
`define MIN_COST_COVERING_SUBSET_SEARCH_UNIT_ASSERT_SVH

// same-cycle implication
`define MCCS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MCCS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/mccs_pkg.sv
// Shared constants and types for the min-cost covering subset search unit.
// No dependencies.
package mccs_pkg;

    localparam int ITEM_W     = 10;
    localparam int NEED_W     = 14;
    localparam int TOTAL_W    = 14;
    localparam int MASK_OUT_W = 16;
    localparam int CFG_IDX_W  = 8;

    localparam int NUM_NEEDS = 4;
    localparam int NUM_LANES = 5;

    localparam int LANE_PROTEIN  = 0;
    localparam int LANE_FAT      = 1;
    localparam int LANE_CARBS    = 2;
    localparam int LANE_VITAMINS = 3;
    localparam int LANE_COST     = 4;

    localparam logic [CFG_IDX_W-1:0] REG_NEED_PROTEIN  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NEED_FAT      = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NEED_CARBS    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NEED_VITAMINS = 8'd3;

    typedef struct packed {
        logic meets;
        logic beats;
    } mccs_verdict_t;

endpackage

### hdl/mccs_alu.sv
// Shared five-lane add/subtract unit for the path sums.
// Depends on mccs_pkg.
module mccs_alu #(
    parameter int SUM_W = 15,
    parameter int VAL_W = 10
) (
    input  logic [mccs_pkg::NUM_LANES-1:0][SUM_W-1:0] acc,
    input  logic [mccs_pkg::NUM_LANES-1:0][VAL_W-1:0] operand,
    input  logic                                      sub,
    output logic [mccs_pkg::NUM_LANES-1:0][SUM_W-1:0] result
);
    import mccs_pkg::*;

    always_comb
    begin
        for (int k = 0; k < NUM_LANES; k++)
        begin
            if (sub)
            begin
                result[k] = acc[k] - SUM_W'(operand[k]);
            end
            else
            begin
                result[k] = acc[k] + SUM_W'(operand[k]);
            end
        end
    end

endmodule

### hdl/mccs_judge.sv
// Feasibility and ranking compare of the current path against the best record.
// Depends on mccs_pkg.
module mccs_judge #(
    parameter int SUM_W = 15
) (
    input  logic [mccs_pkg::NUM_LANES-1:0][SUM_W-1:0]        sums,
    input  logic [mccs_pkg::NUM_LANES-1:0][SUM_W-1:0]        best,
    input  logic                                             best_valid,
    input  logic [mccs_pkg::NUM_NEEDS-1:0][mccs_pkg::NEED_W-1:0] needs,
    output mccs_pkg::mccs_verdict_t                          verdict
);
    import mccs_pkg::*;

    localparam int CMP_W = (SUM_W > NEED_W) ? SUM_W : NEED_W;

    logic decided;

    always_comb
    begin
        verdict.meets = 1'b1;
        for (int k = 0; k < NUM_NEEDS; k++)
        begin
            if (CMP_W'(sums[k]) < CMP_W'(needs[k]))
            begin
                verdict.meets = 1'b0;
            end
        end

        decided       = 1'b0;
        verdict.beats = 1'b0;
        if (!best_valid)
        begin
            decided       = 1'b1;
            verdict.beats = 1'b1;
        end
        else if (sums[LANE_COST] != best[LANE_COST])
        begin
            decided       = 1'b1;
            verdict.beats = sums[LANE_COST] < best[LANE_COST];
        end
        for (int k = 0; k < NUM_NEEDS; k++)
        begin
            if (!decided && sums[k] != best[k])
            begin
                decided       = 1'b1;
                verdict.beats = sums[k] > best[k];
            end
        end
    end

endmodule

### hdl/min_cost_covering_subset_search_unit.sv
// Top level of the min-cost covering subset search unit: sequencer, item memory,
// best record and output register. Depends on mccs_pkg, mccs_alu, mccs_judge.
//
// Usage:
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the four
//   minimums; always ready, unknown indexes are ignored.
//   Input channel: one beat per ingredient. Beats without last_item are stored
//   (beyond MAX_ITEMS they are dropped). A beat with last_item stores its
//   ingredient and starts the depth-first search; in_ready stays low until
//   the search ends.
//   The search runs on one shared adder and one compare unit: each visited
//   node takes a check, an add or subtract, and a walk step back, with at
//   most 2^(N+1)-1 nodes for N items.
//   Output channel: one result beat per set, held in an output register; the
//   unit accepts new ingredients while that beat waits. If the receiver stalls
//   at the end of the next search, the sequencer waits for the register.
//   Reset clears the minimums, the load count, the sequencer and out_valid.
`include "min_cost_covering_subset_search_unit_assert.svh"

module min_cost_covering_subset_search_unit #(
    parameter int MAX_ITEMS  = 16,
    parameter int VALUE_BITS = 10
) (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mccs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mccs_pkg::NEED_W-1:0]      cfg_data,

    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [mccs_pkg::ITEM_W-1:0]      item_protein,
    input  logic [mccs_pkg::ITEM_W-1:0]      item_fat,
    input  logic [mccs_pkg::ITEM_W-1:0]      item_carbs,
    input  logic [mccs_pkg::ITEM_W-1:0]      item_vitamins,
    input  logic [mccs_pkg::ITEM_W-1:0]      item_cost,
    input  logic                             last_item,

    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [mccs_pkg::MASK_OUT_W-1:0]  chosen_mask,
    output logic                             found,
    output logic [mccs_pkg::TOTAL_W-1:0]     total_cost,
    output logic [mccs_pkg::TOTAL_W-1:0]     total_protein,
    output logic [mccs_pkg::TOTAL_W-1:0]     total_fat,
    output logic [mccs_pkg::TOTAL_W-1:0]     total_carbs,
    output logic [mccs_pkg::TOTAL_W-1:0]     total_vitamins
);
    import mccs_pkg::*;

    localparam int VAL_W = (VALUE_BITS < ITEM_W) ? VALUE_BITS : ITEM_W;
    localparam int IDX_W = $clog2(MAX_ITEMS + 1);
    localparam int AW    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int SUM_W = VAL_W + IDX_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_VISIT = 3'd1;
    localparam logic [2:0] ST_ADD   = 3'd2;
    localparam logic [2:0] ST_BACK  = 3'd3;
    localparam logic [2:0] ST_SUB   = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    typedef logic [NUM_LANES-1:0][VAL_W-1:0] entry_t;
    typedef logic [NUM_LANES-1:0][SUM_W-1:0] sums_t;

    entry_t mem [MAX_ITEMS];
    entry_t rd_data_reg;
    entry_t wr_data;
    logic [AW-1:0] rd_addr;

    logic [NUM_NEEDS-1:0][NEED_W-1:0] need_reg;

    logic [2:0]           state_reg, state_next;
    logic [IDX_W-1:0]     count_reg, count_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [IDX_W-1:0]     idx_m1;
    logic [MAX_ITEMS-1:0] mask_reg, mask_next;
    sums_t                sums_reg, sums_next;
    logic [MAX_ITEMS-1:0] best_mask_reg, best_mask_next;
    sums_t                best_sums_reg, best_sums_next;
    logic                 best_valid_reg, best_valid_next;

    logic                  out_valid_reg, out_valid_next;
    logic [MASK_OUT_W-1:0] mask_out_reg, mask_out_next;
    logic                  found_reg, found_next;
    logic [NUM_LANES-1:0][TOTAL_W-1:0] tot_reg, tot_next;

    sums_t         alu_result;
    mccs_verdict_t verdict;
    logic          in_fire;
    logic          store_en;

    mccs_alu #(
        .SUM_W (SUM_W),
        .VAL_W (VAL_W)
    ) u_alu (
        .acc     (sums_reg),
        .operand (rd_data_reg),
        .sub     (state_reg == ST_SUB),
        .result  (alu_result)
    );

    mccs_judge #(
        .SUM_W (SUM_W)
    ) u_judge (
        .sums       (sums_reg),
        .best       (best_sums_reg),
        .best_valid (best_valid_reg),
        .needs      (need_reg),
        .verdict    (verdict)
    );

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign store_en  = in_fire && (count_reg < IDX_W'(MAX_ITEMS));
    assign idx_m1    = idx_reg - 1'b1;
    assign rd_addr   = (state_reg == ST_BACK) ? idx_m1[AW-1:0] : idx_reg[AW-1:0];

    always_comb
    begin
        wr_data[LANE_PROTEIN]  = VAL_W'(item_protein);
        wr_data[LANE_FAT]      = VAL_W'(item_fat);
        wr_data[LANE_CARBS]    = VAL_W'(item_carbs);
        wr_data[LANE_VITAMINS] = VAL_W'(item_vitamins);
        wr_data[LANE_COST]     = VAL_W'(item_cost);
    end

    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            mem[count_reg[AW-1:0]] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            need_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_NEED_PROTEIN:  need_reg[LANE_PROTEIN]  <= cfg_data;
                REG_NEED_FAT:      need_reg[LANE_FAT]      <= cfg_data;
                REG_NEED_CARBS:    need_reg[LANE_CARBS]    <= cfg_data;
                REG_NEED_VITAMINS: need_reg[LANE_VITAMINS] <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        mask_next       = mask_reg;
        sums_next       = sums_reg;
        best_mask_next  = best_mask_reg;
        best_sums_next  = best_sums_reg;
        best_valid_next = best_valid_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        mask_out_next   = mask_out_reg;
        found_next      = found_reg;
        tot_next        = tot_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (store_en)
                begin
                    count_next = count_reg + 1'b1;
                end
                if (in_fire && last_item)
                begin
                    state_next      = ST_VISIT;
                    idx_next        = '0;
                    mask_next       = '0;
                    sums_next       = '0;
                    best_mask_next  = '0;
                    best_sums_next  = '0;
                    best_valid_next = 1'b0;
                end
            end
            ST_VISIT:
            begin
                if (verdict.meets)
                begin
                    if (verdict.beats)
                    begin
                        best_valid_next = 1'b1;
                        best_mask_next  = mask_reg;
                        best_sums_next  = sums_reg;
                    end
                    state_next = ST_BACK;
                end
                else if (idx_reg >= count_reg)
                begin
                    state_next = ST_BACK;
                end
                else
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                sums_next                     = alu_result;
                mask_next[idx_reg[AW-1:0]]    = 1'b1;
                idx_next                      = idx_reg + 1'b1;
                state_next                    = ST_VISIT;
            end
            ST_BACK:
            begin
                if (idx_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else if (mask_reg[idx_m1[AW-1:0]])
                begin
                    mask_next[idx_m1[AW-1:0]] = 1'b0;
                    state_next                = ST_SUB;
                end
                else
                begin
                    idx_next = idx_m1;
                end
            end
            ST_SUB:
            begin
                sums_next  = alu_result;
                state_next = ST_VISIT;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    found_next     = best_valid_reg;
                    mask_out_next  = best_valid_reg ? MASK_OUT_W'(best_mask_reg) : '0;
                    for (int k = 0; k < NUM_LANES; k++)
                    begin
                        tot_next[k] = best_valid_reg ? TOTAL_W'(best_sums_reg[k]) : '0;
                    end
                    count_next      = '0;
                    best_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            idx_reg        <= '0;
            mask_reg       <= '0;
            best_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            mask_reg       <= mask_next;
            best_valid_reg <= best_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sums_reg      <= sums_next;
        best_mask_reg <= best_mask_next;
        best_sums_reg <= best_sums_next;
        mask_out_reg  <= mask_out_next;
        found_reg     <= found_next;
        tot_reg       <= tot_next;
    end

    assign out_valid      = out_valid_reg;
    assign chosen_mask    = mask_out_reg;
    assign found          = found_reg;
    assign total_cost     = tot_reg[LANE_COST];
    assign total_protein  = tot_reg[LANE_PROTEIN];
    assign total_fat      = tot_reg[LANE_FAT];
    assign total_carbs    = tot_reg[LANE_CARBS];
    assign total_vitamins = tot_reg[LANE_VITAMINS];

    `MCCS_ASSERT_SAME(a_mask_below_idx, state_reg != ST_IDLE, (mask_reg >> idx_reg) == '0, "path mask has a bit at or above the search depth")
    `MCCS_ASSERT_SAME(a_idx_in_range, state_reg != ST_IDLE, idx_reg <= count_reg, "search depth beyond loaded count")
    `MCCS_ASSERT_SAME(a_empty_when_not_found, out_valid_reg && !found_reg, (mask_out_reg == '0) && (tot_reg == '0), "result without a feasible subset is not zero")
    `MCCS_ASSERT_NEXT(a_back_to_idle, (state_reg == ST_DONE) && !out_valid_reg, (state_reg == ST_IDLE) && out_valid_reg, "finished search not handed to output register")

endmodule
